// ===== sv/stok_pkg.sv =====
// Shared types, token codes and character tables for the script tokenizer.
// No dependencies; every other file but stok_streams imports this package.
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

	localparam int OFFSET_BITS_DEF = 16;

	// Result queue: room for the two tokens one byte can cause, plus slack.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_NUMBER  = 3'd1,
		M_IDENT   = 3'd2,
		M_STRING  = 3'd3,
		M_COMMENT = 3'd4
	} mode_t;

	localparam logic [4:0] TT_EOF      = 5'd0;
	localparam logic [4:0] TT_EOL      = 5'd1;
	localparam logic [4:0] TT_NUMBER   = 5'd2;
	localparam logic [4:0] TT_IDENT    = 5'd3;
	localparam logic [4:0] TT_STRING   = 5'd4;
	localparam logic [4:0] TT_LPAREN   = 5'd5;
	localparam logic [4:0] TT_RPAREN   = 5'd6;
	localparam logic [4:0] TT_LBRACKET = 5'd7;
	localparam logic [4:0] TT_RBRACKET = 5'd8;
	localparam logic [4:0] TT_DOT      = 5'd9;
	localparam logic [4:0] TT_COMMA    = 5'd10;
	localparam logic [4:0] TT_PLUS     = 5'd11;
	localparam logic [4:0] TT_MINUS    = 5'd12;
	localparam logic [4:0] TT_STAR     = 5'd13;
	localparam logic [4:0] TT_SLASH    = 5'd14;
	localparam logic [4:0] TT_PERCENT  = 5'd15;
	localparam logic [4:0] TT_UNKNOWN  = 5'd16;
	localparam logic [4:0] TT_KEYWORD0 = 5'd17;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_QUOTE = "\"";
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam int NKW = 10;

	// Keyword text, first byte in the low bits, zero padded.
	localparam logic [63:0] KW_CHARS [NKW] = '{
		64'h0000_0000_0064_6E61,  // and
		64'h0000_0000_6573_6C65,  // else
		64'h0000_0000_0064_6E65,  // end
		64'h0000_0000_0000_6669,  // if
		64'h0000_0000_0072_6F66,  // for
		64'h6E6F_6974_636E_7566,  // function
		64'h0000_0000_0074_6F6E,  // not
		64'h0000_0000_0000_726F,  // or
		64'h0000_0000_0072_6176,  // var
		64'h0000_0065_6C69_6877   // while
	};
	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd3, 4'd4, 4'd3, 4'd2, 4'd3, 4'd8, 4'd3, 4'd2, 4'd3, 4'd5
	};

	typedef struct packed {
		logic [4:0]  token_type;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic [15:0] line_number;
		logic        last_of_run;
	} tok_t;

	// Tokens caused by one byte, in output order.
	typedef struct packed {
		logic [1:0] count;
		tok_t       tok0;
		tok_t       tok1;
	} emit_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic [4:0] kw_lookup(input logic [63:0] chars, input logic [3:0] len);
		logic [4:0] t;
		t = TT_IDENT;
		for (int k = NKW - 1; k >= 0; k--) begin
			if ((chars == KW_CHARS[k]) && (len == KW_LEN[k])) begin
				t = TT_KEYWORD0 + 5'(k);
			end
		end
		return t;
	endfunction

	function automatic logic [4:0] punct_type(input logic [7:0] c);
		logic [4:0] t;
		case (c)
			"(": t = TT_LPAREN;
			")": t = TT_RPAREN;
			"[": t = TT_LBRACKET;
			"]": t = TT_RBRACKET;
			".": t = TT_DOT;
			",": t = TT_COMMA;
			"+": t = TT_PLUS;
			"-": t = TT_MINUS;
			"*": t = TT_STAR;
			"/": t = TT_SLASH;
			"%": t = TT_PERCENT;
			default: t = TT_UNKNOWN;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== sv/stok_streams.sv =====
// Valid/ready stream interfaces for the tokenizer: source bytes in, tokens out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface stok_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface stok_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_type;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic        last_of_run;

	modport source (output valid, output token_type, output start_offset,
		output token_length, output line_number, output last_of_run, input ready);
	modport sink (input valid, input token_type, input start_offset,
		input token_length, input line_number, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/script_tokenizer.sv =====
// Top level of the script tokenizer: input register, scanner and result queue.
// Depends on stok_pkg, stok_streams (interfaces) and stok_scan.
`timescale 1ns / 1ps
`default_nettype none

// The tokenizer takes one source byte per cycle on chars and delivers tokens on
// tokens, each with its type, start offset, length, line and a flag that marks the
// last token a byte caused. An accepted byte waits in the input register until the
// scanner classifies it and updates its mode; the tokens it causes are then written
// to the result queue, whose head is offered on tokens. A byte that closes one token
// and opens another yields both tokens in the cycle it is scanned; they wait in the
// four-entry result queue, and a byte is scanned only when the queue has room for
// two. The rate is therefore one byte per cycle for as long as the token side
// drains the queue, which moves one token per cycle; runs that average more than
// one token per byte proceed at the pace of the token side.

module script_tokenizer
	import stok_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	stok_byte_if.sink     chars,
	stok_token_if.source  tokens
);

	logic              byte_valid_s1;
	logic [7:0]        byte_s1;
	logic              step;
	emit_t             emit;

	tok_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	tok_t              head;

	assign step        = byte_valid_s1 && (count_q <= QCNT_W'(QDEPTH - 2));
	assign chars.ready = !byte_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			byte_valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1 <= chars.char_byte;
		end
	end

	stok_scan #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.c      (byte_s1),
		.emit   (emit)
	);

	assign pop = tokens.valid && tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (step) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(emit.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (step ? QCNT_W'(emit.count) : QCNT_W'(0))
				- (pop ? QCNT_W'(1) : QCNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (step && (emit.count != 2'd0)) begin
			queue_q[wr_ptr_q] <= emit.tok0;
		end
		if (step && (emit.count == 2'd2)) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= emit.tok1;
		end
	end

	assign head                = queue_q[rd_ptr_q];
	assign tokens.valid        = (count_q != '0);
	assign tokens.token_type   = head.token_type;
	assign tokens.start_offset = head.start_offset;
	assign tokens.token_length = head.token_length;
	assign tokens.line_number  = head.line_number;
	assign tokens.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

// ===== sv/stok_scan.sv =====
// Scanner state and per-byte token logic: one byte in, up to two tokens out.
// Depends on stok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stok_scan
	import stok_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] c,
	output emit_t           emit
);

	localparam int OB = OFFSET_BITS;
	localparam logic [OB-1:0] CNT_MAX = '1;
	localparam logic [OB-1:0] CNT_ONE = OB'(1);

	mode_t         mode_q, mode_n;
	logic [OB-1:0] byte_offset_q, line_count_q, token_start_q, token_line_q, run_len_q;
	logic [OB-1:0] byte_offset_n, line_count_n, token_start_n, token_line_n, run_len_n;
	logic [63:0]   ident_chars_q, ident_chars_n;
	logic [3:0]    ident_len_q, ident_len_n;

	logic          a_v, b_v, rescan;
	logic [4:0]    a_type, b_type;
	logic [OB-1:0] a_len, run_grown;
	logic          b_len_one;
	tok_t          tok_a, tok_b;

	function automatic logic [15:0] to16(input logic [OB-1:0] x);
		logic [OB+15:0] w;
		w = {16'b0, x};
		return w[15:0];
	endfunction

	always_comb begin
		mode_n        = mode_q;
		token_start_n = token_start_q;
		token_line_n  = token_line_q;
		run_len_n     = run_len_q;
		ident_chars_n = ident_chars_q;
		ident_len_n   = ident_len_q;
		a_v           = 1'b0;
		a_type        = TT_EOF;
		a_len         = run_len_q;
		b_v           = 1'b0;
		b_type        = TT_EOF;
		b_len_one     = 1'b1;
		rescan        = 1'b0;
		run_grown     = (run_len_q == CNT_MAX) ? run_len_q : run_len_q + CNT_ONE;

		case (mode_q)
			M_NUMBER: begin
				if (is_digit(c)) begin
					run_len_n = run_grown;
				end else begin
					a_v    = 1'b1;
					a_type = TT_NUMBER;
					mode_n = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_letter(c) || is_digit(c)) begin
					run_len_n = run_grown;
					if (ident_len_q < 4'd8) begin
						ident_chars_n = ident_chars_q | ({56'b0, c} << {ident_len_q[2:0], 3'b000});
					end
					if (ident_len_q != 4'd15) begin
						ident_len_n = ident_len_q + 4'd1;
					end
				end else begin
					a_v    = 1'b1;
					a_type = kw_lookup(ident_chars_q, ident_len_q);
					mode_n = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_STRING, M_COMMENT: begin
				a_type = (mode_q == M_STRING) ? TT_STRING : TT_EOL;
				if (c == CH_NUL) begin
					// An unterminated string or comment closes before the EOF token.
					a_v    = 1'b1;
					mode_n = M_IDLE;
					rescan = 1'b1;
				end else begin
					run_len_n = run_grown;
					a_len     = run_grown;
					if ((mode_q == M_STRING) ? (c == CH_QUOTE) : (c == CH_NL)) begin
						a_v    = 1'b1;
						mode_n = M_IDLE;
					end
				end
			end
			default: begin
				mode_n = M_IDLE;
				rescan = 1'b1;
			end
		endcase

		if (rescan && !((c != CH_NL) && (c != CH_NUL) && ((c <= CH_SPACE) || c[7]))) begin
			token_start_n = byte_offset_q;
			token_line_n  = line_count_q;
			run_len_n     = CNT_ONE;
			ident_chars_n = '0;
			ident_len_n   = 4'd0;
			mode_n        = M_IDLE;
			if (c == CH_NUL) begin
				run_len_n = '0;
				b_v       = 1'b1;
				b_type    = TT_EOF;
				b_len_one = 1'b0;
			end else if (c == CH_NL) begin
				b_v    = 1'b1;
				b_type = TT_EOL;
			end else if (c == CH_HASH) begin
				mode_n = M_COMMENT;
			end else if (c == CH_QUOTE) begin
				mode_n = M_STRING;
			end else if (is_digit(c)) begin
				mode_n = M_NUMBER;
			end else if (is_letter(c)) begin
				mode_n        = M_IDENT;
				ident_chars_n = {56'b0, c};
				ident_len_n   = 4'd1;
			end else begin
				b_v    = 1'b1;
				b_type = (c == CH_DEL) ? TT_UNKNOWN : punct_type(c);
			end
		end

		byte_offset_n = (c != CH_NUL) ? byte_offset_q + CNT_ONE : byte_offset_q;
		line_count_n  = ((c == CH_NL) && (line_count_q != CNT_MAX)) ?
			line_count_q + CNT_ONE : line_count_q;
	end

	always_comb begin
		tok_a.token_type   = a_type;
		tok_a.start_offset = to16(token_start_q);
		tok_a.token_length = to16(a_len);
		tok_a.line_number  = to16(token_line_q);
		tok_a.last_of_run  = !b_v;

		tok_b.token_type   = b_type;
		tok_b.start_offset = to16(byte_offset_q);
		tok_b.token_length = {15'b0, b_len_one};
		tok_b.line_number  = to16(line_count_q);
		tok_b.last_of_run  = 1'b1;

		emit.count = {1'b0, a_v} + {1'b0, b_v};
		emit.tok0  = a_v ? tok_a : tok_b;
		emit.tok1  = tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_IDLE;
			byte_offset_q <= '0;
			line_count_q  <= CNT_ONE;
			token_start_q <= '0;
			token_line_q  <= CNT_ONE;
			run_len_q     <= '0;
			ident_chars_q <= '0;
			ident_len_q   <= 4'd0;
		end else if (step) begin
			mode_q        <= mode_n;
			byte_offset_q <= byte_offset_n;
			line_count_q  <= line_count_n;
			token_start_q <= token_start_n;
			token_line_q  <= token_line_n;
			run_len_q     <= run_len_n;
			ident_chars_q <= ident_chars_n;
			ident_len_q   <= ident_len_n;
		end
	end

endmodule

`default_nettype wire

// ===== test/script_tokenizer_chk.sv =====
// Scoreboard for the script tokenizer: tracks the byte and token streams,
// predicts tokens per accepted byte and compares them. Depends on stok_pkg and stok_streams.
`timescale 1ns / 1ps

module script_tokenizer_chk
	import stok_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	stok_byte_if      chars,
	stok_token_if     tokens,
	output int        fails,
	output int        pending,
	output int        checked
);

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam int NUM_KEYWORDS = 10;

	// Predicted scanner state.
	mode_t       lex_mode = M_IDLE;
	logic [15:0] cur_offset = '0;
	logic [15:0] cur_line = 16'd1;
	logic [15:0] tok_start = '0;
	logic [15:0] tok_line = 16'd1;
	logic [15:0] run_len = '0;
	logic [63:0] word_bytes = '0;
	logic [3:0]  word_len = '0;

	tok_t expected_tokens [$];
	tok_t step_toks [2];
	int   n_step;

	function automatic string keyword_text(input int k);
		case (k)
			0: return "and";
			1: return "else";
			2: return "end";
			3: return "if";
			4: return "for";
			5: return "function";
			6: return "not";
			7: return "or";
			8: return "var";
			default: return "while";
		endcase
	endfunction

	function automatic logic num_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	// Identifiers only become keywords on an exact spelling; words longer than
	// eight bytes can never match since no keyword is that long.
	function automatic logic [4:0] word_kind();
		string kw;
		logic  same;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			kw = keyword_text(k);
			same = (int'(word_len) == kw.len());
			for (int i = 0; same && i < kw.len(); i++) begin
				if (word_bytes[8*i +: 8] != 8'(kw[i])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				return TT_KEYWORD0 + 5'(k);
			end
		end
		return TT_IDENT;
	endfunction

	task automatic add_tok(input logic [4:0] kind);
		tok_t t;
		t.token_type   = kind;
		t.start_offset = tok_start;
		t.token_length = run_len;
		t.line_number  = tok_line;
		t.last_of_run  = 1'b0;
		step_toks[n_step] = t;
		n_step++;
	endtask

	task automatic open_tok(input mode_t m);
		lex_mode   = m;
		tok_start  = cur_offset;
		tok_line   = cur_line;
		run_len    = 16'd1;
		word_bytes = '0;
		word_len   = '0;
	endtask

	task automatic grow_tok();
		if (run_len != COUNT_MAX) begin
			run_len++;
		end
	endtask

	task automatic keep_word_byte(input logic [7:0] c);
		if (word_len < 4'd8) begin
			word_bytes[8*word_len +: 8] = c;
		end
		if (word_len != 4'd15) begin
			word_len++;
		end
	endtask

	task automatic scan_from_idle(input logic [7:0] c);
		if (c == CH_NUL) begin
			open_tok(M_IDLE);
			run_len = '0;
			add_tok(TT_EOF);
		end else if (c == CH_NL) begin
			open_tok(M_IDLE);
			add_tok(TT_EOL);
		end else if (c <= CH_SPACE || c[7]) begin
			// Whitespace and high bytes open nothing.
		end else if (c == CH_HASH) begin
			open_tok(M_COMMENT);
		end else if (c == CH_QUOTE) begin
			open_tok(M_STRING);
		end else if (num_char(c)) begin
			open_tok(M_NUMBER);
		end else if (word_char(c)) begin
			open_tok(M_IDENT);
			keep_word_byte(c);
		end else begin
			open_tok(M_IDLE);
			case (c)
				"(": add_tok(TT_LPAREN);
				")": add_tok(TT_RPAREN);
				"[": add_tok(TT_LBRACKET);
				"]": add_tok(TT_RBRACKET);
				".": add_tok(TT_DOT);
				",": add_tok(TT_COMMA);
				"+": add_tok(TT_PLUS);
				"-": add_tok(TT_MINUS);
				"*": add_tok(TT_STAR);
				"/": add_tok(TT_SLASH);
				"%": add_tok(TT_PERCENT);
				default: add_tok(TT_UNKNOWN);
			endcase
		end
	endtask

	// One byte: close the open token if this byte cannot extend it, rescan the
	// byte from idle where needed, then advance offset and line.
	task automatic predict_tokens(input logic [7:0] c);
		logic rescan;
		rescan = 1'b0;
		n_step = 0;
		case (lex_mode)
			M_NUMBER: begin
				if (num_char(c)) begin
					grow_tok();
				end else begin
					add_tok(TT_NUMBER);
					lex_mode = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_IDENT: begin
				if (word_char(c) || num_char(c)) begin
					grow_tok();
					keep_word_byte(c);
				end else begin
					add_tok(word_kind());
					lex_mode = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_STRING: begin
				if (c == CH_NUL) begin
					add_tok(TT_STRING);
					lex_mode = M_IDLE;
					rescan = 1'b1;
				end else begin
					grow_tok();
					if (c == CH_QUOTE) begin
						add_tok(TT_STRING);
						lex_mode = M_IDLE;
					end
				end
			end
			M_COMMENT: begin
				if (c == CH_NUL) begin
					add_tok(TT_EOL);
					lex_mode = M_IDLE;
					rescan = 1'b1;
				end else begin
					grow_tok();
					if (c == CH_NL) begin
						add_tok(TT_EOL);
						lex_mode = M_IDLE;
					end
				end
			end
			default: begin
				lex_mode = M_IDLE;
				rescan = 1'b1;
			end
		endcase
		if (rescan) begin
			scan_from_idle(c);
		end
		if (c != CH_NUL) begin
			cur_offset++;
		end
		if (c == CH_NL && cur_line != COUNT_MAX) begin
			cur_line++;
		end
		if (n_step > 0) begin
			step_toks[n_step - 1].last_of_run = 1'b1;
		end
		for (int i = 0; i < n_step; i++) begin
			expected_tokens.push_back(step_toks[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_token();
		tok_t want;
		if (expected_tokens.size() == 0) begin
			$error("token type %0d at offset %0d arrived with nothing expected",
				tokens.token_type, tokens.start_offset);
			fails++;
		end else begin
			want = expected_tokens.pop_front();
			check_field("token_type", 16'(want.token_type), 16'(tokens.token_type));
			check_field("start_offset", want.start_offset, tokens.start_offset);
			check_field("token_length", want.token_length, tokens.token_length);
			check_field("line_number", want.line_number, tokens.line_number);
			check_field("last_of_run", 16'(want.last_of_run), 16'(tokens.last_of_run));
			checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_mode   = M_IDLE;
			cur_offset = '0;
			cur_line   = 16'd1;
			tok_start  = '0;
			tok_line   = 16'd1;
			run_len    = '0;
			word_bytes = '0;
			word_len   = '0;
			expected_tokens.delete();
			pending <= 0;
		end else begin
			// A byte's tokens cannot leave in the cycle of its own transfer.
			if (tokens.valid && tokens.ready) begin
				check_token();
			end
			if (chars.valid && chars.ready) begin
				predict_tokens(chars.char_byte);
			end
			pending <= expected_tokens.size();
		end
	end

endmodule

// ===== test/script_tokenizer_tb.sv =====
// Testbench top for the script tokenizer: clock, reset, source byte stimulus and token-side
// back-pressure. Depends on stok_pkg, stok_streams, script_tokenizer, script_tokenizer_chk.
`timescale 1ns / 1ps

module script_tokenizer_tb
	import stok_pkg::*;
();

	localparam int RANDOM_BYTES = 1900;
	localparam int NUM_PHASES = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;

	int idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int fails;
	int pending;
	int checked;
	int dir_bytes;

	string word_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string word_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string marks = "()[].,+-*/%!$&:;<=>?@^{|}~'\\";
	string breaks = " ()+,.\n\t*";

	stok_byte_if  chars_if ();
	stok_token_if tokens_if ();

	script_tokenizer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	script_tokenizer_chk u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.tokens  (tokens_if),
		.fails   (fails),
		.pending (pending),
		.checked (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("script_tokenizer: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		tokens_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [7:0] pick(input string s);
		return 8'(s[$urandom_range(s.len() - 1)]);
	endfunction

	function automatic string keyword_text(input int k);
		case (k)
			0: return "and";
			1: return "else";
			2: return "end";
			3: return "if";
			4: return "for";
			5: return "function";
			6: return "not";
			7: return "or";
			8: return "var";
			default: return "while";
		endcase
	endfunction

	// Valid stays high across back-to-back transfers; it drops only when an idle
	// stretch is chosen before the next byte, or in wait_drained.
	task automatic send_byte(input logic [7:0] b);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			chars_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_byte <= b;
		do @(posedge clk); while (!chars_if.ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(8'(s[i]));
		end
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_word(input string w);
		send_text(w);
		if ($urandom_range(99) < 60) begin
			send_byte(pick(breaks));
		end
	endtask

	task automatic send_fragment();
		string      w;
		int         r;
		int         n;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 16) begin
			send_word(keyword_text($urandom_range(9)));
		end else if (r < 20) begin
			// Near misses: a keyword with a byte dropped or added.
			w = keyword_text($urandom_range(9));
			if ($urandom_range(1) == 0) begin
				w = w.substr(0, w.len() - 2);
			end else begin
				w = {w, string'(pick(word_tail))};
			end
			send_word(w);
		end else if (r < 34) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			w = string'(pick(word_head));
			for (int i = 1; i < n; i++) begin
				w = {w, string'(pick(word_tail))};
			end
			send_word(w);
		end else if (r < 44) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				send_byte(8'($urandom_range("0", "9")));
			end
		end else if (r < 54) begin
			send_byte(CH_QUOTE);
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(99);
				if (r < 80) begin
					// Printable bytes, with the quote swapped for an apostrophe.
					b = 8'($urandom_range(32, 126));
					send_byte((b == CH_QUOTE) ? 8'h27 : b);
				end else if (r < 90) begin
					send_byte(CH_NL);
				end else begin
					send_byte(8'($urandom_range(128, 255)));
				end
			end
			send_byte(($urandom_range(9) == 0) ? CH_NUL : CH_QUOTE);
		end else if (r < 61) begin
			send_byte(CH_HASH);
			n = $urandom_range(0, 10);
			for (int i = 0; i < n; i++) begin
				send_byte(($urandom_range(7) == 0) ? 8'($urandom_range(128, 255))
					: 8'($urandom_range(32, 126)));
			end
			send_byte(($urandom_range(9) == 0) ? CH_NUL : CH_NL);
		end else if (r < 76) begin
			send_byte(($urandom_range(19) == 0) ? CH_DEL : pick(marks));
		end else if (r < 89) begin
			r = $urandom_range(5);
			case (r)
				0: send_byte(CH_SPACE);
				1: send_byte(CH_NL);
				2: send_byte(8'h09);
				3: send_byte(8'h0D);
				4: send_byte(8'($urandom_range(1, 32)));
				default: send_byte(8'($urandom_range(128, 255)));
			endcase
		end else if (r < 98) begin
			send_byte(8'($urandom_range(1, 255)));
		end else begin
			send_byte(CH_NUL);
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.char_byte = CH_NUL;
		tokens_if.ready    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: EOF with nothing open, a skipped high byte, tokens that
		// end on the byte that starts the next, a string across a newline, a
		// comment, the delete byte, and a string and a comment cut off by EOF.
		send_byte(CH_NUL);
		send_byte(8'hFF);
		send_text("12+");
		send_text("a_9Z\t");
		send_text("\"s\n\"");
		send_text("#c\n");
		send_byte(CH_DEL);
		send_text("or\"");
		send_byte(CH_NUL);
		send_byte(CH_HASH);
		send_byte(CH_NUL);
		send_text("function.\n");
		dir_bytes = bytes_sent;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 69; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 69; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			while (bytes_sent < dir_bytes + (ph + 1) * RANDOM_BYTES / NUM_PHASES) begin
				send_fragment();
			end
			// Let the token side catch up completely once mid-run.
			if (ph == 3) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("script_tokenizer_tb: %0d source bytes under four idle/stall mixes,",
			bytes_sent);
		$display("script_tokenizer_tb: %0d tokens checked", checked);
		if (fails == 0 && pending == 0) begin
			$display("script_tokenizer: match");
		end else begin
			$display("script_tokenizer: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/stok_pkg.sv
sv/stok_streams.sv
sv/stok_scan.sv
sv/script_tokenizer.sv
test/script_tokenizer_chk.sv
test/script_tokenizer_tb.sv
